// ===== src/mhp_pkg.sv =====
package mhp_pkg;

  // Parser phase, one-hot
  typedef enum logic [4:0] {
    PH_ADDR  = 5'b00001,
    PH_COUNT = 5'b00010,
    PH_DHI   = 5'b00100,
    PH_DLO   = 5'b01000,
    PH_DATA  = 5'b10000
  } phase_e;

  typedef enum logic [1:0] {
    K_HDR  = 2'd0,
    K_DESC = 2'd1,
    K_DATA = 2'd2,
    K_ERR  = 2'd3
  } rec_kind_e;

  localparam int unsigned TdataW = 48;

  typedef struct packed {
    rec_kind_e   kind;
    logic [3:0]  src_addr;
    logic [3:0]  dst_addr;
    logic [7:0]  sdu_count;
    logic [7:0]  sdu_index;
    logic        dc_flag;
    logic [14:0] sdu_size;
    logic [7:0]  data_out;
    logic        last;
  } rec_t;

  localparam rec_t RecZero = '{
    kind: K_HDR, src_addr: '0, dst_addr: '0, sdu_count: '0, sdu_index: '0,
    dc_flag: 1'b0, sdu_size: '0, data_out: '0, last: 1'b0
  };

endpackage

// ===== src/mhp_parser.sv =====
module mhp_parser
  import mhp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] byte_i,
  input  logic       end_i,
  output logic       emit_o,
  output rec_t       rec_o
);

  phase_e     phase_q, phase_d;
  logic [7:0] idx_q, idx_d;
  logic [3:0] src_q, src_d;
  logic [3:0] dst_q, dst_d;
  logic [7:0] cnt_q, cnt_d;
  logic [7:0] dhi_q, dhi_d;
  logic [7:0] idx_inc;
  logic       final_desc;

  assign idx_inc    = idx_q + 8'd1;
  assign final_desc = (idx_inc == cnt_q);

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    src_d   = src_q;
    dst_d   = dst_q;
    cnt_d   = cnt_q;
    dhi_d   = dhi_q;
    emit_o  = 1'b0;
    rec_o   = RecZero;
    unique case (phase_q)
      PH_COUNT: begin
        cnt_d = byte_i;
        idx_d = '0;
        emit_o = 1'b1;
        if (end_i && byte_i != 8'd0) begin
          rec_o.kind = K_ERR;
          rec_o.last = 1'b1;
          phase_d    = PH_ADDR;
        end else begin
          rec_o.kind      = K_HDR;
          rec_o.src_addr  = src_q;
          rec_o.dst_addr  = dst_q;
          rec_o.sdu_count = byte_i;
          rec_o.last      = end_i;
          if (end_i) phase_d = PH_ADDR;
          else if (byte_i == 8'd0) phase_d = PH_DATA;
          else phase_d = PH_DHI;
        end
      end
      PH_DHI: begin
        dhi_d = byte_i;
        if (end_i) begin
          emit_o     = 1'b1;
          rec_o.kind = K_ERR;
          rec_o.last = 1'b1;
          phase_d    = PH_ADDR;
          idx_d      = '0;
        end else begin
          phase_d = PH_DLO;
        end
      end
      PH_DLO: begin
        emit_o = 1'b1;
        if (end_i && !final_desc) begin
          rec_o.kind = K_ERR;
          rec_o.last = 1'b1;
          phase_d    = PH_ADDR;
          idx_d      = '0;
        end else begin
          rec_o.kind      = K_DESC;
          rec_o.sdu_index = idx_q;
          rec_o.dc_flag   = dhi_q[7];
          rec_o.sdu_size  = {dhi_q[6:0], byte_i};
          rec_o.last      = end_i;
          if (end_i) begin
            phase_d = PH_ADDR;
            idx_d   = '0;
          end else begin
            idx_d   = idx_inc;
            phase_d = final_desc ? PH_DATA : PH_DHI;
          end
        end
      end
      PH_DATA: begin
        emit_o         = 1'b1;
        rec_o.kind     = K_DATA;
        rec_o.data_out = byte_i;
        rec_o.last     = end_i;
        if (end_i) phase_d = PH_ADDR;
      end
      default: begin
        // address byte; illegal codes recover here too
        src_d = byte_i[7:4];
        dst_d = byte_i[3:0];
        idx_d = '0;
        if (end_i) begin
          emit_o     = 1'b1;
          rec_o.kind = K_ERR;
          rec_o.last = 1'b1;
          phase_d    = PH_ADDR;
        end else begin
          phase_d = PH_COUNT;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ADDR;
      idx_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
    end
  end

  // held fields are always written before they are read
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      src_q <= src_d;
      dst_q <= dst_d;
      cnt_q <= cnt_d;
      dhi_q <= dhi_d;
    end
  end

endmodule

// ===== src/mac_pdu_header_parser_top.sv =====
// MAC PDU header parser.
//
// Input stream (s_axis): one PDU byte per request in tdata, tlast marks
// the final byte of the PDU. Output stream (m_axis): one record per
// request; tuser carries the record kind (header, SDU descriptor, payload,
// truncated header error), tdata the record fields, tlast marks the
// record caused by the final PDU byte. Address bytes and first descriptor
// bytes produce no record unless they carry tlast.
//
// A record enters the output register, or the skid entry while the
// receiver stalls, when the byte that causes it is accepted.
// Throughput: one byte per cycle while tready is high, set by the phase
// update in the parser; the output keeps up with an always-ready receiver.
//
// Stall: the output register is backed by a one-entry skid buffer, so a
// byte is still taken in the cycle the receiver first stalls; s_axis
// tready drops only once the skid entry is occupied.
//
// Reset: asynchronous, active low; the parser returns to expecting an
// address byte and both output stages are emptied.
module mac_pdu_header_parser_top
  import mhp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [7:0]        s_axis_tdata_i,   // [7:0] pdu_byte
  input  logic              s_axis_tlast_i,   // end_of_pdu
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  // [3:0] src_addr, [7:4] dst_addr, [15:8] sdu_count, [23:16] sdu_index,
  // [24] dc_flag, [39:25] sdu_size, [47:40] data_out
  output logic [TdataW-1:0] m_axis_tdata_o,
  output logic [1:0]        m_axis_tuser_o,   // [1:0] rec_kind
  output logic              m_axis_tlast_o    // last
);

  logic accept;
  logic emit;
  rec_t rec_new;

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  rec_t out_q, out_d;
  rec_t skid_q, skid_d;
  logic out_free;

  assign s_axis_tready_o = !skid_valid_q;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  mhp_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata_i),
    .end_i    (s_axis_tlast_i),
    .emit_o   (emit),
    .rec_o    (rec_new)
  );

  // output stage can load when empty or being drained this cycle
  assign out_free = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else if (accept && emit) begin
        out_d       = rec_new;
        out_valid_d = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (accept && emit) begin
      skid_d       = rec_new;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tlast_o  = out_q.last;
  assign m_axis_tdata_o  = {out_q.data_out, out_q.sdu_size, out_q.dc_flag,
                            out_q.sdu_index, out_q.sdu_count,
                            out_q.dst_addr, out_q.src_addr};

  // skid entry only ever sits behind a full output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid valid with empty output stage");

  // error records carry nothing but kind and last
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == K_ERR) |->
      (m_axis_tdata_o == '0 && m_axis_tlast_o))
    else $error("error record with payload or without last");

  // a parked skid record is kept while the receiver stalls
  a_skid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !m_axis_tready_i) |=> (skid_valid_q && $stable(skid_q)))
    else $error("skid record lost during stall");

  // a record from an accepted byte is never dropped
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && emit) |=> out_valid_q)
    else $error("record dropped");

endmodule
